@@ rtl/apcs_pkg.sv @@
// Shared types and constants for the adjacent pair counter.
// No dependencies.
`timescale 1ns / 1ps

package apcs_pkg;

    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam int FIELD_W = 16;

    localparam logic OP_TOKEN  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_SEL_WALK,
        ST_SEL_LAST,
        ST_SEL_DONE
    } state_t;

endpackage

@@ rtl/adjacent_pair_count_and_select.sv @@
// Top level of the adjacent token pair counter with best-pair select.
// Depends on apcs_pkg.
`timescale 1ns / 1ps

// Counts adjacent token pairs within a line in a hashed table of TABLE_ENTRIES
// entries (one single-port-read, single-port-write RAM, linear probing).
// Each entry holds a valid bit, the pair key, a saturating 32-bit count and
// its insertion sequence number, which breaks ties at select so that the
// pair inserted first wins. After reset the block runs a clearing pass over
// the RAM before it takes any transaction; config writes are taken
// throughout. A token transaction that forms a pair probes the table from
// the hashed slot onward, up to TABLE_ENTRIES slots with a full table; each
// probe costs a RAM read and a check. A select transaction walks the whole
// RAM at one entry per cycle, reading the best candidate and clearing each
// entry as it goes, then waits for the result register to drain if it is
// still full. The result register lets token transactions be taken while a
// select result waits on m_ready.
module adjacent_pair_count_and_select #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int TOKEN_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_token_id,
    input  logic        s_line_end,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_best_first,
    output logic [15:0] m_best_second,
    output logic [31:0] m_best_count,
    output logic        m_found,
    output logic        m_table_overflowed,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDXW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILLW = $clog2(TABLE_ENTRIES + 1);
    localparam int KEYW  = 2 * TOKEN_BITS;
    localparam int CW    = apcs_pkg::COUNT_W;
    // entry layout: {valid, key, count, seq}
    localparam int WORDW = 1 + KEYW + CW + IDXW;
    localparam logic [IDXW-1:0]  LAST_IDX = IDXW'(TABLE_ENTRIES - 1);
    localparam logic [FILLW-1:0] FULL     = FILLW'(TABLE_ENTRIES);

    // configuration
    logic [CW-1:0] min_count_reg;
    logic          cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'b0) ? min_count_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_count_reg <= 32'd2;
        end else if (cfg_wr && paddr[2] == 1'b0) begin
            min_count_reg <= pwdata;
        end
    end

    // table RAM
    logic [WORDW-1:0] mem [TABLE_ENTRIES];
    logic [WORDW-1:0] rdata_reg;
    logic [IDXW-1:0]  raddr;
    logic [IDXW-1:0]  waddr;
    logic [WORDW-1:0] wdata;
    logic             we;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    logic            rd_valid;
    logic [KEYW-1:0] rd_key;
    logic [CW-1:0]   rd_count;
    logic [IDXW-1:0] rd_seq;
    assign rd_valid = rdata_reg[WORDW-1];
    assign rd_key   = rdata_reg[WORDW-2 -: KEYW];
    assign rd_count = rdata_reg[IDXW +: CW];
    assign rd_seq   = rdata_reg[IDXW-1:0];

    // control and datapath registers
    apcs_pkg::state_t state_reg, state_next;
    logic [TOKEN_BITS-1:0] prev_tok_reg, prev_tok_next;
    logic                  prev_vld_reg, prev_vld_next;
    logic [FILLW-1:0]      fill_reg, fill_next;
    logic                  ovf_reg, ovf_next;
    logic [KEYW-1:0]       key_reg, key_next;
    logic [IDXW-1:0]       idx_reg, idx_next;
    logic [FILLW-1:0]      probes_reg, probes_next;
    logic [IDXW-1:0]       walk_reg, walk_next;
    logic                  chk_reg, chk_next;
    logic [IDXW-1:0]       chk_addr_reg, chk_addr_next;
    logic [KEYW-1:0]       best_key_reg, best_key_next;
    logic [CW-1:0]         best_cnt_reg, best_cnt_next;
    logic [IDXW-1:0]       best_seq_reg, best_seq_next;
    logic                  m_valid_reg, m_valid_next;
    logic [15:0]           o_first_reg, o_first_next;
    logic [15:0]           o_second_reg, o_second_next;
    logic [CW-1:0]         o_count_reg, o_count_next;
    logic                  o_found_reg, o_found_next;
    logic                  o_ovf_reg, o_ovf_next;

    logic                  s_fire;
    logic                  out_free;
    logic [TOKEN_BITS-1:0] tok;
    logic [KEYW-1:0]       new_key;
    logic [IDXW-1:0]       hash_fold;
    logic [IDXW-1:0]       hash_idx;
    logic [IDXW-1:0]       idx_succ;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign tok      = TOKEN_BITS'(s_token_id);
    assign new_key  = {prev_tok_reg, tok};
    assign idx_succ = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // xor-fold of the pair key onto the index width
    always_comb begin
        hash_fold = '0;
        for (int i = 0; i < KEYW; i++) begin
            hash_fold[i % IDXW] = hash_fold[i % IDXW] ^ new_key[i];
        end
        hash_idx = (FILLW'(hash_fold) >= FULL) ? IDXW'(FILLW'(hash_fold) - FULL)
                                               : hash_fold;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            apcs_pkg::ST_CLEAR: begin
                if (walk_reg == LAST_IDX) state_next = apcs_pkg::ST_IDLE;
            end
            apcs_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == apcs_pkg::OP_SELECT) begin
                        state_next = apcs_pkg::ST_SEL_WALK;
                    end else if (prev_vld_reg) begin
                        state_next = apcs_pkg::ST_PROBE_RD;
                    end
                end
            end
            apcs_pkg::ST_PROBE_RD: begin
                state_next = apcs_pkg::ST_PROBE_CHK;
            end
            apcs_pkg::ST_PROBE_CHK: begin
                if (!rd_valid || rd_key == key_reg || probes_reg == FILLW'(TABLE_ENTRIES - 1))
                    state_next = apcs_pkg::ST_IDLE;
                else
                    state_next = apcs_pkg::ST_PROBE_RD;
            end
            apcs_pkg::ST_SEL_WALK: begin
                if (walk_reg == LAST_IDX) state_next = apcs_pkg::ST_SEL_LAST;
            end
            apcs_pkg::ST_SEL_LAST: begin
                state_next = apcs_pkg::ST_SEL_DONE;
            end
            apcs_pkg::ST_SEL_DONE: begin
                if (out_free) state_next = apcs_pkg::ST_IDLE;
            end
            default: state_next = apcs_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready       = (state_reg == apcs_pkg::ST_IDLE);
        raddr         = idx_reg;
        waddr         = idx_reg;
        wdata         = '0;
        we            = 1'b0;
        prev_tok_next = prev_tok_reg;
        prev_vld_next = prev_vld_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        probes_next   = probes_reg;
        walk_next     = walk_reg;
        chk_next      = 1'b0;
        chk_addr_next = chk_addr_reg;
        best_key_next = best_key_reg;
        best_cnt_next = best_cnt_reg;
        best_seq_next = best_seq_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_first_next  = o_first_reg;
        o_second_next = o_second_reg;
        o_count_next  = o_count_reg;
        o_found_next  = o_found_reg;
        o_ovf_next    = o_ovf_reg;

        unique case (state_reg)
            apcs_pkg::ST_CLEAR: begin
                we        = 1'b1;
                waddr     = walk_reg;
                walk_next = (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;
            end
            apcs_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == apcs_pkg::OP_SELECT) begin
                        walk_next     = '0;
                        best_key_next = '0;
                        best_cnt_next = '0;
                        best_seq_next = '0;
                    end else begin
                        key_next      = new_key;
                        idx_next      = hash_idx;
                        probes_next   = '0;
                        prev_vld_next = !s_line_end;
                        prev_tok_next = tok;
                    end
                end
            end
            apcs_pkg::ST_PROBE_RD: begin
                raddr = idx_reg;
            end
            apcs_pkg::ST_PROBE_CHK: begin
                if (rd_valid && rd_key == key_reg) begin
                    we    = 1'b1;
                    wdata = {1'b1, rd_key,
                             (rd_count == apcs_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1,
                             rd_seq};
                end else if (!rd_valid) begin
                    if (fill_reg != FULL) begin
                        we        = 1'b1;
                        wdata     = {1'b1, key_reg, CW'(1), IDXW'(fill_reg)};
                        fill_next = fill_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end else if (probes_reg == FILLW'(TABLE_ENTRIES - 1)) begin
                    ovf_next = 1'b1;
                end else begin
                    idx_next    = idx_succ;
                    probes_next = probes_reg + 1'b1;
                end
            end
            apcs_pkg::ST_SEL_WALK, apcs_pkg::ST_SEL_LAST: begin
                if (state_reg == apcs_pkg::ST_SEL_WALK) begin
                    raddr         = walk_reg;
                    chk_next      = 1'b1;
                    chk_addr_next = walk_reg;
                    walk_next     = (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;
                end
                if (chk_reg) begin
                    // clear the entry as it is scanned
                    we    = 1'b1;
                    waddr = chk_addr_reg;
                    if (rd_valid && (rd_count > best_cnt_reg ||
                        (rd_count == best_cnt_reg && rd_seq < best_seq_reg))) begin
                        best_key_next = rd_key;
                        best_cnt_next = rd_count;
                        best_seq_next = rd_seq;
                    end
                end
            end
            apcs_pkg::ST_SEL_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_first_next  = 16'(best_key_reg[KEYW-1:TOKEN_BITS]);
                    o_second_next = 16'(best_key_reg[TOKEN_BITS-1:0]);
                    o_count_next  = best_cnt_reg;
                    o_found_next  = (best_cnt_reg >= min_count_reg);
                    o_ovf_next    = ovf_reg;
                    fill_next     = '0;
                    ovf_next      = 1'b0;
                    prev_vld_next = 1'b0;
                    prev_tok_next = '0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= apcs_pkg::ST_CLEAR;
            prev_tok_reg <= '0;
            prev_vld_reg <= 1'b0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            walk_reg     <= '0;
            chk_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prev_tok_reg <= prev_tok_next;
            prev_vld_reg <= prev_vld_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            walk_reg     <= walk_next;
            chk_reg      <= chk_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        probes_reg   <= probes_next;
        chk_addr_reg <= chk_addr_next;
        best_key_reg <= best_key_next;
        best_cnt_reg <= best_cnt_next;
        best_seq_reg <= best_seq_next;
        o_first_reg  <= o_first_next;
        o_second_reg <= o_second_next;
        o_count_reg  <= o_count_next;
        o_found_reg  <= o_found_next;
        o_ovf_reg    <= o_ovf_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_best_first       = o_first_reg;
    assign m_best_second      = o_second_reg;
    assign m_best_count       = o_count_reg;
    assign m_found            = o_found_reg;
    assign m_table_overflowed = o_ovf_reg;

endmodule

@@ tb/sv/apcs_checker.sv @@
// Checker for the adjacent pair counter: watches the input, result and config ports,
// predicts every select result, and compares it field by field. Depends on apcs_pkg.
`timescale 1ns / 1ps

module apcs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_token_id,
    input  logic        s_line_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_best_first,
    input  logic [15:0] m_best_second,
    input  logic [31:0] m_best_count,
    input  logic        m_found,
    input  logic        m_table_overflowed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam int ENTRIES = 4096;
    localparam logic [2:0] ADDR_MIN_COUNT = 3'd0;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] second;
        logic [31:0] count;
        logic        found;
        logic        ovf;
    } best_pair_t;

    best_pair_t  best_q[$];
    logic [31:0] pair_keys[$];
    logic [31:0] pair_counts[$];
    int          slot_of[logic [31:0]];
    logic [15:0] prev_tok;
    logic        prev_ok;
    logic        ovf_seen;
    logic [31:0] min_count;

    initial begin
        fail_count = 0;
        pending    = 0;
        prev_tok   = '0;
        prev_ok    = 1'b0;
        ovf_seen   = 1'b0;
        min_count  = 32'd2;
    end

    function automatic void count_pair(logic [15:0] a, logic [15:0] b);
        logic [31:0] key;
        key = {a, b};
        if (slot_of.exists(key)) begin
            if (pair_counts[slot_of[key]] != apcs_pkg::COUNT_MAX)
                pair_counts[slot_of[key]] = pair_counts[slot_of[key]] + 32'd1;
        end else if (pair_keys.size() < ENTRIES) begin
            slot_of[key] = pair_keys.size();
            pair_keys    = {pair_keys, key};
            pair_counts  = {pair_counts, 32'd1};
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    function automatic best_pair_t pick_best();
        best_pair_t  r;
        logic [31:0] bkey;
        logic [31:0] bcnt;
        bkey = '0;
        bcnt = '0;
        // strict compare keeps the earliest inserted pair on a tie
        for (int i = 0; i < pair_keys.size(); i++) begin
            if (pair_counts[i] > bcnt) begin
                bcnt = pair_counts[i];
                bkey = pair_keys[i];
            end
        end
        r.first  = bkey[31:16];
        r.second = bkey[15:0];
        r.count  = bcnt;
        r.found  = (bcnt >= min_count);
        r.ovf    = ovf_seen;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MIN_COUNT)
                min_count <= pwdata;

            if (s_valid && s_ready) begin
                if (s_opcode == apcs_pkg::OP_TOKEN) begin
                    if (prev_ok)
                        count_pair(prev_tok, s_token_id);
                    prev_ok  = !s_line_end;
                    prev_tok = s_line_end ? prev_tok : s_token_id;
                end else begin
                    best_q = {best_q, pick_best()};
                    pair_keys.delete();
                    pair_counts.delete();
                    slot_of.delete();
                    ovf_seen = 1'b0;
                    prev_ok  = 1'b0;
                    prev_tok = '0;
                end
            end

            if (m_valid && m_ready) begin
                if (best_q.size() == 0) begin
                    $display("%0t: unexpected result %h %h %h %b %b", $time, m_best_first,
                             m_best_second, m_best_count, m_found, m_table_overflowed);
                    fail_count++;
                end else begin
                    best_pair_t e;
                    e = best_q.pop_front();
                    if (e.first !== m_best_first || e.second !== m_best_second
                            || e.count !== m_best_count || e.found !== m_found
                            || e.ovf !== m_table_overflowed) begin
                        $display("%0t: mismatch expected %h %h %h %b %b actual %h %h %h %b %b",
                                 $time, e.first, e.second, e.count, e.found, e.ovf,
                                 m_best_first, m_best_second, m_best_count, m_found,
                                 m_table_overflowed);
                        fail_count++;
                    end
                end
            end
            pending = best_q.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for adjacent_pair_count_and_select: makes stimulus and config writes,
// and gives the verdict. Depends on apcs_pkg, apcs_checker and the block itself.
`timescale 1ns / 1ps

module tb;

    localparam int  ENTRIES     = 4096;
    localparam int  SETTLE      = 2 * ENTRIES + 64;   // worst probe or walk, with slack
    localparam int  PHASE_ITEMS = 450;
    localparam longint CYCLE_LIMIT = 50000000;
    localparam logic [2:0] ADDR_MIN_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;   // no register here, write ignored

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = apcs_pkg::OP_TOKEN;
    logic [15:0] s_token_id = '0;
    logic        s_line_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_best_first;
    logic [15:0] m_best_second;
    logic [31:0] m_best_count;
    logic        m_found;
    logic        m_table_overflowed;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int     fail_count;
    int     pending;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    longint cycles = 0;

    always #5 aclk = ~aclk;

    adjacent_pair_count_and_select u_top (.*);

    apcs_checker u_chk (.*);

    // receiver stalls at its own rate
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one transaction; the sender idles each cycle at its own rate before it
    task automatic send(logic op, logic [15:0] tok, logic le);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_token_id <= tok;
        s_line_end <= le;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    // drain results, then let any in-flight probe finish before touching config
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly lines over a small alphabet so pairs repeat and tie; some wide ids
    task automatic random_phase(int n);
        logic [15:0] alpha[8];
        int          asz;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                asz = $urandom_range(2, 8);
                foreach (alpha[k]) alpha[k] = 16'($urandom_range(16'hFFFF));
            end
            if ($urandom_range(24) == 0)
                send(apcs_pkg::OP_SELECT, 16'($urandom_range(16'hFFFF)),
                     1'($urandom_range(1)));
            else if ($urandom_range(3) == 0)
                send(apcs_pkg::OP_TOKEN, 16'($urandom_range(16'hFFFF)),
                     $urandom_range(4) == 0);
            else
                send(apcs_pkg::OP_TOKEN, alpha[$urandom_range(asz - 1)],
                     $urandom_range(4) == 0);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table with default minimum of two
        send(apcs_pkg::OP_SELECT, 16'h0, 1'b0);
        // extremes of the id, a repeated pair, and a line break
        send(apcs_pkg::OP_TOKEN, 16'hFFFF, 1'b0);
        send(apcs_pkg::OP_TOKEN, 16'h0000, 1'b0);
        send(apcs_pkg::OP_TOKEN, 16'hFFFF, 1'b0);
        send(apcs_pkg::OP_TOKEN, 16'h0000, 1'b1);
        send(apcs_pkg::OP_TOKEN, 16'h0005, 1'b0);
        send(apcs_pkg::OP_TOKEN, 16'h0005, 1'b1);
        send(apcs_pkg::OP_SELECT, 16'hFFFF, 1'b1);
        // tie between two single pairs, both below the minimum
        send(apcs_pkg::OP_TOKEN, 16'h0001, 1'b0);
        send(apcs_pkg::OP_TOKEN, 16'h0002, 1'b1);
        send(apcs_pkg::OP_TOKEN, 16'h0003, 1'b0);
        send(apcs_pkg::OP_TOKEN, 16'h0004, 1'b1);
        send(apcs_pkg::OP_SELECT, 16'h0, 1'b0);
        // pending token must not pair across a select
        send(apcs_pkg::OP_TOKEN, 16'h0007, 1'b0);
        send(apcs_pkg::OP_SELECT, 16'h0, 1'b0);
        send(apcs_pkg::OP_TOKEN, 16'h0008, 1'b1);
        send(apcs_pkg::OP_SELECT, 16'h0, 1'b0);
        wait_idle();
        apb_write(ADDR_MIN_COUNT, 32'd0);
        apb_write(ADDR_UNUSED, 32'd9);
        send(apcs_pkg::OP_SELECT, 16'h0, 1'b0);

        wait_idle();
        apb_write(ADDR_MIN_COUNT, $urandom_range(1, 6));
        send_idle_pct = 15;
        recv_idle_pct = 54;
        random_phase(PHASE_ITEMS);

        wait_idle();
        apb_write(ADDR_MIN_COUNT, 32'hFFFF_FFFF);
        send_idle_pct = 54;
        recv_idle_pct = 15;
        random_phase(PHASE_ITEMS);

        wait_idle();
        apb_write(ADDR_MIN_COUNT, 32'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_ITEMS);
        send(apcs_pkg::OP_SELECT, 16'h0, 1'b0);

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
